FILE: hdl/assert_macros.svh
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, disabled in reset
`define ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: hdl/trl_pkg.sv
// ----------------------------------------------------------------------------
// trl_pkg
// Shared types and constants for the TLB refill block.
// ----------------------------------------------------------------------------
package trl_pkg;
  localparam int Frames     = 32;
  localparam int TlbEntries = 4;
  localparam int PageSize   = 128;
  localparam int FrW  = $clog2(Frames);
  localparam int SlW  = $clog2(TlbEntries);
  localparam int VpnW = 25;
  localparam int OffW = $clog2(PageSize);

  localparam logic [1:0] StFound = 2'd0;
  localparam logic [1:0] StRefill = 2'd1;
  localparam logic [1:0] StAddrErr = 2'd2;
  localparam logic [1:0] StDirty = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_SRCH_CHK, S_VICT, S_VICT_CHK, S_EVICT, S_EVICT2, S_INST,
    S_TSEL, S_TOLD, S_TOLD2, S_TFR, S_TNEW, S_OUT
  } state_e;

  typedef struct packed {
    logic clr_idx;    // frame index := 0
    logic inc_idx;
    logic rd;         // issue frame read at idx
    logic srch_cmp;   // compare read data for match
    logic vict_cmp;   // compare read data for LRU
    logic rd_victim;  // read at victim
    logic evict;      // pull dirty bit, write victim info
    logic install;    // write new page
    logic tsel;       // pick TLB slot
    logic rd_old;     // read frame of evicted slot
    logic wr_old;     // write back evicted dirty bit
    logic tnew;       // write TLB and frame slot/last use
    logic err;
    logic dirty;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic match;
    logic invalid_hit;
    logic addr_err;
    logic old_valid;
  } sts_t;
endpackage

FILE: hdl/trl_ram.sv
// ----------------------------------------------------------------------------
// trl_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module trl_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: hdl/trl_ctrl.sv
// ----------------------------------------------------------------------------
// trl_ctrl
// Sequencer for mark-dirty requests and the refill: search, victim scan, install, TLB fill.
// ----------------------------------------------------------------------------
module trl_ctrl import trl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic kind_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.clr_idx = 1'b1;
        if (in_valid_i) begin
          if (kind_i) begin
            cmd_o.dirty = 1'b1;
            state_d = S_OUT;
          end else begin
            state_d = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        cmd_o.rd = 1'b1;
        state_d = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        cmd_o.srch_cmp = 1'b1;
        if (sts_i.match) state_d = S_TSEL;
        else if (!sts_i.idx_last) begin
          cmd_o.inc_idx = 1'b1;
          state_d = S_SRCH;
        end else if (sts_i.addr_err) begin
          cmd_o.err = 1'b1;
          state_d = S_OUT;
        end else begin
          cmd_o.clr_idx = 1'b1;
          state_d = S_VICT;
        end
      end
      S_VICT: begin
        cmd_o.rd = 1'b1;
        state_d = S_VICT_CHK;
      end
      S_VICT_CHK: begin
        cmd_o.vict_cmp = 1'b1;
        if (sts_i.invalid_hit || sts_i.idx_last) state_d = S_EVICT;
        else begin
          cmd_o.inc_idx = 1'b1;
          state_d = S_VICT;
        end
      end
      S_EVICT: begin
        cmd_o.rd_victim = 1'b1;
        state_d = S_EVICT2;
      end
      S_EVICT2: begin
        cmd_o.evict = 1'b1;
        state_d = S_INST;
      end
      S_INST: begin
        cmd_o.install = 1'b1;
        state_d = S_TSEL;
      end
      S_TSEL: begin
        cmd_o.tsel = 1'b1;
        state_d = S_TOLD;
      end
      S_TOLD: begin
        if (sts_i.old_valid) begin
          cmd_o.rd_old = 1'b1;
          state_d = S_TOLD2;
        end else state_d = S_TFR;
      end
      S_TOLD2: begin
        cmd_o.wr_old = 1'b1;
        state_d = S_TFR;
      end
      // fresh read of the mapped frame, after any dirty write-back
      S_TFR: begin
        cmd_o.rd_victim = 1'b1;
        state_d = S_TNEW;
      end
      S_TNEW: begin
        cmd_o.tnew = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

FILE: hdl/trl_dp.sv
// ----------------------------------------------------------------------------
// trl_dp
// Frame table RAM, TLB registers and result registers.
// ----------------------------------------------------------------------------
module trl_dp import trl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_fire_i,
  input  logic [31:0]       fault_address_i,
  input  logic [7:0]        pid_i,
  input  logic [25:0]       page_limit_i,
  input  logic [31:0]       now_i,
  input  logic [1:0]        dirty_slot_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic [1:0]        status_o,
  output logic [4:0]        frame_o,
  output logic [1:0]        slot_used_o,
  output logic              needs_writeback_o,
  output logic [7:0]        victim_pid_o,
  output logic [24:0]       victim_vpn_o
);
  // frame record: owner, page, dirty, in_tlb, slot, last_use
  localparam int RecW = 8 + VpnW + 1 + 1 + SlW + 32;
  typedef struct packed {
    logic [7:0]      owner;
    logic [VpnW-1:0] page;
    logic            dirty;
    logic            in_tlb;
    logic [SlW-1:0]  slot;
    logic [31:0]     last_use;
  } rec_t;

  logic [Frames-1:0] fvalid_q;
  logic [TlbEntries-1:0] tvalid_q, tdirty_q;
  logic [FrW-1:0] tframe_q [TlbEntries];
  logic [SlW-1:0] fifo_q;

  logic [FrW-1:0] idx_q, fr_q, addr;
  logic [VpnW-1:0] vpn_q;
  logic [7:0] pid_q;
  logic [25:0] limit_q;
  logic [31:0] now_q, best_lu_q;
  logic [SlW-1:0] slot_q;
  logic [1:0] dslot_q;
  logic kind_q, err_q, found_q, wb_q, inv_q;
  logic [7:0] vpid_q;
  logic [VpnW-1:0] vvpn_q;

  rec_t rd, wr;
  logic we;
  logic [RecW-1:0] rdata;
  assign rd = rec_t'(rdata);

  // slot pick: first invalid else fifo pointer
  logic [SlW-1:0] pick;
  always_comb begin
    pick = fifo_q;
    for (int j = TlbEntries - 1; j >= 0; j--) if (!tvalid_q[j]) pick = SlW'(j);
  end

  always_comb begin
    addr = idx_q;
    we = 1'b0;
    wr = rd;
    if (cmd_i.rd_victim || cmd_i.evict || cmd_i.install || cmd_i.tnew) addr = fr_q;
    if (cmd_i.rd_old || cmd_i.wr_old) addr = tframe_q[slot_q];
    if (cmd_i.evict) begin
      we = 1'b1;
      if (rd.in_tlb) wr.dirty = tdirty_q[rd.slot];
    end
    if (cmd_i.install) begin
      we = 1'b1;
      wr.owner = pid_q; wr.page = vpn_q; wr.dirty = 1'b0;
      wr.in_tlb = 1'b0; wr.slot = '0; wr.last_use = '0;
    end
    if (cmd_i.wr_old) begin
      we = 1'b1;
      wr.dirty = tdirty_q[slot_q];
      wr.in_tlb = 1'b0;
    end
    if (cmd_i.tnew) begin
      we = 1'b1;
      wr.slot = slot_q; wr.in_tlb = 1'b1; wr.last_use = now_q;
    end
  end

  trl_ram #(.Width(RecW), .Depth(Frames)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wr), .rdata_o(rdata)
  );

  assign sts_o.idx_last = (idx_q == FrW'(Frames - 1));
  assign sts_o.match = fvalid_q[idx_q] && rd.owner == pid_q && rd.page == vpn_q;
  assign sts_o.invalid_hit = !fvalid_q[idx_q];
  assign sts_o.addr_err = {1'b0, vpn_q} >= limit_q;
  assign sts_o.old_valid = tvalid_q[slot_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fvalid_q <= '0; tvalid_q <= '0; tdirty_q <= '0; fifo_q <= '0;
    end else begin
      if (cmd_i.dirty && {1'b0, dirty_slot_i} < 3'(TlbEntries))
        tdirty_q[dirty_slot_i[SlW-1:0]] <= 1'b1;
      if (cmd_i.evict && fvalid_q[fr_q] && rd.in_tlb) tvalid_q[rd.slot] <= 1'b0;
      if (cmd_i.install) fvalid_q[fr_q] <= 1'b1;
      if (cmd_i.tsel) fifo_q <= pick + SlW'(1);
      if (cmd_i.tnew) begin
        tvalid_q[slot_q] <= 1'b1;
        tdirty_q[slot_q] <= rd.dirty;
        tframe_q[slot_q] <= fr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      kind_q <= cmd_i.dirty;
      vpn_q <= fault_address_i[31:OffW];
      pid_q <= pid_i; limit_q <= page_limit_i; now_q <= now_i;
      dslot_q <= dirty_slot_i;
      err_q <= 1'b0; found_q <= 1'b0; wb_q <= 1'b0; inv_q <= 1'b0;
      vpid_q <= '0; vvpn_q <= '0; fr_q <= '0; slot_q <= '0;
    end
    if (cmd_i.clr_idx) idx_q <= '0;
    else if (cmd_i.inc_idx) idx_q <= idx_q + FrW'(1);
    if (cmd_i.srch_cmp && sts_o.match) begin
      found_q <= 1'b1; fr_q <= idx_q;
    end
    if (cmd_i.err) err_q <= 1'b1;
    if (cmd_i.vict_cmp && !inv_q) begin
      if (!fvalid_q[idx_q]) begin
        inv_q <= 1'b1; fr_q <= idx_q;
      end else if (idx_q == '0 || rd.last_use < best_lu_q) begin
        best_lu_q <= rd.last_use; fr_q <= idx_q;
      end
    end
    if (cmd_i.evict && fvalid_q[fr_q]) begin
      wb_q <= rd.in_tlb ? tdirty_q[rd.slot] : rd.dirty;
      vpid_q <= rd.owner; vvpn_q <= rd.page;
    end
    if (cmd_i.tsel) slot_q <= pick;
  end

  always_comb begin
    status_o = found_q ? StFound : StRefill;
    frame_o = 5'(fr_q); slot_used_o = 2'(slot_q);
    needs_writeback_o = wb_q; victim_pid_o = vpid_q; victim_vpn_o = vvpn_q;
    if (kind_q) begin
      status_o = StDirty; frame_o = '0; slot_used_o = dslot_q;
      needs_writeback_o = 1'b0; victim_pid_o = '0; victim_vpn_o = '0;
    end else if (err_q) begin
      status_o = StAddrErr; frame_o = '0; slot_used_o = '0;
      needs_writeback_o = 1'b0; victim_pid_o = '0; victim_vpn_o = '0;
    end
  end
endmodule

FILE: hdl/tlb_refill_inverted_table_lru.sv
// ----------------------------------------------------------------------------
// tlb_refill_inverted_table_lru
// TLB miss handler over an inverted frame table with LRU frame replacement.
// ----------------------------------------------------------------------------
// A mark-dirty request answers in the cycle after it is taken. A lookup reads
// frames in turn to a match, picks a TLB slot, writes back its dirty bit when
// the slot was valid, and fills it; a refill searches all frames, scans them
// for an invalid or LRU victim, evicts, installs and fills. One item at a time,
// set by the single frame RAM port that the search and LRU scans step through.
// Reset: asynchronous, clears all valid bits, dirty bits and FIFO pointer;
// frame RAM contents are left as is and read only behind a valid bit.
module tlb_refill_inverted_table_lru import trl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [31:0] fault_address_i,
  input  logic [7:0]  pid_i,
  input  logic [25:0] page_limit_i,
  input  logic [31:0] now_i,
  input  logic [1:0]  dirty_slot_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [4:0]  frame_o,
  output logic [1:0]  slot_used_o,
  output logic        needs_writeback_o,
  output logic [7:0]  victim_pid_o,
  output logic [24:0] victim_vpn_o
);
  cmd_t cmd;
  sts_t sts;

  // controller owns the handshake; datapath holds the tables
  trl_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i,
    .out_valid_o, .out_ready_i, .sts_i(sts), .cmd_o(cmd)
  );

  trl_dp u_dp (
    .clk_i, .rst_ni, .in_fire_i(in_valid_i && in_ready_o),
    .fault_address_i, .pid_i, .page_limit_i, .now_i, .dirty_slot_i,
    .cmd_i(cmd), .sts_o(sts),
    .status_o, .frame_o, .slot_used_o, .needs_writeback_o,
    .victim_pid_o, .victim_vpn_o
  );
endmodule

FILE: hdl/trl_checker.sv
// ----------------------------------------------------------------------------
// trl_checker
// Port-level checks for the TLB refill block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module trl_checker import trl_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] status_o,
  input logic [1:0] slot_used_o,
  input logic [1:0] dirty_slot_i,
  input logic       kind_i
);
  `ASSERT_IMP(a_excl, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `ASSERT_NEXT(a_dirty, clk_i, rst_ni, in_valid_i && in_ready_o && kind_i,
      out_valid_o && status_o == StDirty && slot_used_o == $past(dirty_slot_i))
  `ASSERT_NEXT(a_free, clk_i, rst_ni, out_valid_o && out_ready_i, in_ready_o)
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
      out_valid_o && $stable(status_o))
endmodule

bind tlb_refill_inverted_table_lru trl_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .status_o, .slot_used_o, .dirty_slot_i, .kind_i
);
